### sv/slr_pkg.sv
// Shared constants and request/result types for the spectrum linear resampler.
`timescale 1ns / 1ps

package slr_pkg;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned BANK_DEPTH  = STORE_DEPTH / 2;
  localparam int unsigned BANK_AW     = IDX_W - 1;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned POINT_W     = 16;
  localparam int unsigned STEP_W      = 24;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned POS_W       = POINT_W + STEP_W;
  localparam int unsigned LOWER_W     = POS_W - FRAC_BITS;
  localparam int unsigned DIFF_W      = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W      = DIFF_W + FRAC_BITS + 1;
  localparam int unsigned INC_W       = PROD_W - FRAC_BITS;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [LEN_W-1:0]  LEN_RESET  = '0;
  localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(STORE_DEPTH);

  // register select, taken from paddr bit 2
  typedef enum logic {
    REG_STEP_RATIO   = 1'b0,
    REG_INPUT_LENGTH = 1'b1
  } reg_e;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef struct packed {
    op_e                           operation;
    logic [IDX_W-1:0]              sample_index;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [POINT_W-1:0]            point_number;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] interpolated_value;
    logic                          in_range;
  } result_t;

endpackage

### sv/spectrum_linear_resampler.sv
// Linear interpolation resampler: a request passes the position, store read, product and output registers to the ports.
// A new item is taken every cycle (busy stays low); a write lands at the edge that takes it.
// The two neighbors come from even/odd store banks, one read port each, in the same cycle.
// Reset clears the pipeline and sets step_ratio to 1.0 and input_length to 0;
// store contents are undefined until written. Results cannot be stalled.
`timescale 1ns / 1ps

module spectrum_linear_resampler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  slr_pkg::item_t                item_i,
  output logic                          result_valid_o,
  output slr_pkg::result_t              result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slr_pkg::ADDR_W-1:0]    paddr,
  input  logic [slr_pkg::DATA_W-1:0]    pwdata,
  output logic [slr_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [slr_pkg::STEP_W-1:0] step_q;
  logic [slr_pkg::LEN_W-1:0]  len_q;
  logic                       cfg_we;
  slr_pkg::reg_e              cfg_sel;

  logic                       accept;
  logic                       wr_en;

  // stage 1: position
  logic                        v1_q;
  logic [slr_pkg::POS_W-1:0]   pos_q;
  logic [slr_pkg::POS_W-1:0]   pos_d;
  logic [slr_pkg::LOWER_W-1:0] lower;
  logic [slr_pkg::LEN_W-1:0]   len_sat;
  logic                        in_range1;

  // stage 2: store read
  logic                          v2_q;
  logic                          inr2_q;
  logic [slr_pkg::FRAC_BITS-1:0] frac2_q;
  logic [slr_pkg::SAMPLE_BITS-1:0] y_lo;
  logic [slr_pkg::SAMPLE_BITS-1:0] y_hi;
  logic signed [slr_pkg::DIFF_W-1:0] diff;
  logic signed [slr_pkg::PROD_W-1:0] prod_d;

  // stage 3: product
  logic                              v3_q;
  logic                              inr3_q;
  logic signed [slr_pkg::PROD_W-1:0] prod_q;
  logic [slr_pkg::SAMPLE_BITS-1:0]   y1_3_q;
  logic [slr_pkg::INC_W-1:0]         inc;
  logic [slr_pkg::SAMPLE_BITS-1:0]   sum;

  // stage 4: output register
  logic             res_v_q;
  slr_pkg::result_t res_q;
  slr_pkg::result_t res_d;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = slr_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= slr_pkg::STEP_RESET;
      len_q  <= slr_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_sel)
        slr_pkg::REG_STEP_RATIO:   step_q <= pwdata[slr_pkg::STEP_W-1:0];
        slr_pkg::REG_INPUT_LENGTH: len_q  <= pwdata[slr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      slr_pkg::REG_STEP_RATIO:   prdata = slr_pkg::DATA_W'(step_q);
      slr_pkg::REG_INPUT_LENGTH: prdata = slr_pkg::DATA_W'(len_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- request intake ----------------
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wr_en  = accept && (item_i.operation == slr_pkg::OP_WRITE);
  assign pos_d  = slr_pkg::POS_W'(item_i.point_number) * slr_pkg::POS_W'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      v1_q    <= accept && (item_i.operation == slr_pkg::OP_REQUEST);
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      res_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  // ---------------- stage 1: range check, read issue ----------------
  assign lower     = pos_q[slr_pkg::POS_W-1:slr_pkg::FRAC_BITS];
  assign len_sat   = (len_q > slr_pkg::LEN_MAX) ? slr_pkg::LEN_MAX : len_q;
  assign in_range1 = ({1'b0, lower} + (slr_pkg::LOWER_W + 1)'(1))
                     < (slr_pkg::LOWER_W + 1)'(len_sat);

  slr_sample_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (item_i.sample_index),
    .wr_data_i (item_i.sample_value),
    .rd_en_i   (v1_q),
    .rd_idx_i  (lower[slr_pkg::IDX_W-1:0]),
    .lo_data_o (y_lo),
    .hi_data_o (y_hi)
  );

  always_ff @(posedge clk_i) begin
    inr2_q  <= in_range1;
    frac2_q <= pos_q[slr_pkg::FRAC_BITS-1:0];
  end

  // ---------------- stage 2: difference times weight ----------------
  assign diff   = $signed({y_hi[slr_pkg::SAMPLE_BITS-1], y_hi})
                - $signed({y_lo[slr_pkg::SAMPLE_BITS-1], y_lo});
  assign prod_d = $signed({1'b0, frac2_q}) * diff;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    y1_3_q <= y_lo;
    inr3_q <= inr2_q;
  end

  // ---------------- stage 3: floor shift and add ----------------
  // arithmetic part-select gives floor(prod / 2^16)
  assign inc = prod_q[slr_pkg::PROD_W-1:slr_pkg::FRAC_BITS];
  assign sum = y1_3_q + inc[slr_pkg::SAMPLE_BITS-1:0];

  always_comb begin
    res_d.in_range           = inr3_q;
    res_d.interpolated_value = inr3_q ? $signed(sum) : '0;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule

### sv/slr_sample_store.sv
// Sample store split into even and odd banks so two neighbors read in the same cycle.
`timescale 1ns / 1ps

module slr_sample_store (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [slr_pkg::IDX_W-1:0]        wr_idx_i,
  input  logic [slr_pkg::SAMPLE_BITS-1:0]  wr_data_i,
  input  logic                             rd_en_i,
  input  logic [slr_pkg::IDX_W-1:0]        rd_idx_i,
  output logic [slr_pkg::SAMPLE_BITS-1:0]  lo_data_o,
  output logic [slr_pkg::SAMPLE_BITS-1:0]  hi_data_o
);

  logic [slr_pkg::SAMPLE_BITS-1:0] even_mem [slr_pkg::BANK_DEPTH];
  logic [slr_pkg::SAMPLE_BITS-1:0] odd_mem  [slr_pkg::BANK_DEPTH];

  logic [slr_pkg::BANK_AW-1:0]     even_addr;
  logic [slr_pkg::BANK_AW-1:0]     odd_addr;
  logic [slr_pkg::SAMPLE_BITS-1:0] even_q;
  logic [slr_pkg::SAMPLE_BITS-1:0] odd_q;
  logic                            sel_q;

  // an odd lower index takes its upper neighbor from the next even row
  assign odd_addr  = rd_idx_i[slr_pkg::IDX_W-1:1];
  assign even_addr = rd_idx_i[0] ? odd_addr + slr_pkg::BANK_AW'(1) : odd_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_idx_i[0]) begin
      even_mem[wr_idx_i[slr_pkg::IDX_W-1:1]] <= wr_data_i;
    end
    if (rd_en_i) begin
      even_q <= even_mem[even_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i[0]) begin
      odd_mem[wr_idx_i[slr_pkg::IDX_W-1:1]] <= wr_data_i;
    end
    if (rd_en_i) begin
      odd_q <= odd_mem[odd_addr];
      sel_q <= rd_idx_i[0];
    end
  end

  assign lo_data_o = sel_q ? odd_q : even_q;
  assign hi_data_o = sel_q ? even_q : odd_q;

endmodule

### sim/tb_spectrum_linear_resampler.sv
// Self-checking testbench for the spectrum linear resampler: writes, point requests, registers.
`timescale 1ns / 1ps

module tb_spectrum_linear_resampler;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  slr_pkg::item_t                item_i;
  logic                          result_valid_o;
  slr_pkg::result_t              result_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [slr_pkg::ADDR_W-1:0]    paddr;
  logic [slr_pkg::DATA_W-1:0]    pwdata;
  logic [slr_pkg::DATA_W-1:0]    prdata;
  logic                          pready;

  spectrum_linear_resampler uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Mirror of the resampler: register shadows, sample store, pending interpolations.
  class resample_scoreboard;
    logic [slr_pkg::STEP_W-1:0]             step;
    logic [slr_pkg::LEN_W-1:0]              length;
    logic signed [slr_pkg::SAMPLE_BITS-1:0] store [slr_pkg::STORE_DEPTH];
    bit                                     written [slr_pkg::STORE_DEPTH];
    slr_pkg::result_t                       expected_q [$];
    int                                     errors;
    int                                     n_writes;
    int                                     n_hits;
    int                                     n_misses;

    function new();
      step   = slr_pkg::STEP_RESET;
      length = slr_pkg::LEN_RESET;
    endfunction

    function void set_reg(slr_pkg::reg_e r, logic [slr_pkg::DATA_W-1:0] v);
      if (r == slr_pkg::REG_STEP_RATIO) begin
        step = v[slr_pkg::STEP_W-1:0];
      end else begin
        length = v[slr_pkg::LEN_W-1:0];
      end
    endfunction

    function logic [slr_pkg::DATA_W-1:0] reg_value(slr_pkg::reg_e r);
      return (r == slr_pkg::REG_STEP_RATIO) ? slr_pkg::DATA_W'(step)
                                            : slr_pkg::DATA_W'(length);
    endfunction

    // input_length saturates at the store depth
    function int unsigned usable_length();
      return (length > slr_pkg::STORE_DEPTH) ? slr_pkg::STORE_DEPTH : int'(length);
    endfunction

    function longint unsigned lower_index(logic [slr_pkg::POINT_W-1:0] p);
      longint unsigned pos;
      pos = longint'(p) * longint'(step);
      return pos >> slr_pkg::FRAC_BITS;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(slr_pkg::item_t it);
      longint unsigned  pos;
      longint unsigned  lower;
      longint           frac;
      longint           y1;
      longint           y2;
      longint           diff;
      longint           incr;
      slr_pkg::result_t r;
      if (it.operation == slr_pkg::OP_WRITE) begin
        store[it.sample_index]   = it.sample_value;
        written[it.sample_index] = 1'b1;
        n_writes++;
        return;
      end
      pos   = longint'(it.point_number) * longint'(step);
      lower = pos >> slr_pkg::FRAC_BITS;
      frac  = longint'(pos & 64'hFFFF);
      r     = '0;
      if (lower + 1 < usable_length()) begin
        y1   = store[lower];
        y2   = store[lower + 1];
        diff = y2 - y1;
        // arithmetic shift of a signed product floors toward minus infinity
        incr = (frac * diff) >>> slr_pkg::FRAC_BITS;
        r.interpolated_value = slr_pkg::SAMPLE_BITS'(y1 + incr);
        r.in_range           = 1'b1;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(slr_pkg::result_t got);
      slr_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: value %0d in_range %0b",
               got.interpolated_value, got.in_range);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.in_range) n_hits++;
      else n_misses++;
      if (got.interpolated_value !== exp_r.interpolated_value) begin
        $error("interpolated_value: expected %0d, got %0d",
               exp_r.interpolated_value, got.interpolated_value);
        errors++;
      end
      if (got.in_range !== exp_r.in_range) begin
        $error("in_range: expected %0b, got %0b", exp_r.in_range, got.in_range);
        errors++;
      end
    endfunction
  endclass

  resample_scoreboard sb;
  int                 idle_pct;
  int                 n_settings;
  int unsigned        cycles;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) sb.check_result(result_o);
  end

  function automatic logic signed [slr_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Favor points that land inside the stored span, edge included.
  function automatic logic [slr_pkg::POINT_W-1:0] pick_point();
    longint unsigned span;
    int unsigned     len_v;
    len_v = sb.usable_length();
    if ($urandom_range(9) < 4 || sb.step == 0 || len_v < 2) begin
      return slr_pkg::POINT_W'($urandom_range(0, 65535));
    end
    span = ((longint'(len_v) - 1) << slr_pkg::FRAC_BITS) / sb.step + 1;
    if (span > 65535) span = 65535;
    return slr_pkg::POINT_W'($urandom_range(0, int'(span)));
  endfunction

  task automatic idle_cycle();
    @(negedge clk_i) start <= 1'b0;
  endtask

  task automatic push_item(slr_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_item(it);
  endtask

  task automatic store_sample(logic [slr_pkg::IDX_W-1:0] idx,
                              logic signed [slr_pkg::SAMPLE_BITS-1:0] val);
    slr_pkg::item_t it;
    it.operation    = slr_pkg::OP_WRITE;
    it.sample_index = idx;
    it.sample_value = val;
    it.point_number = slr_pkg::POINT_W'($urandom);
    push_item(it);
  endtask

  // Both neighbors of an in-range point are written before the request goes out.
  task automatic request_point(logic [slr_pkg::POINT_W-1:0] p);
    slr_pkg::item_t  it;
    longint unsigned lower;
    lower = sb.lower_index(p);
    if (lower + 1 < sb.usable_length()) begin
      for (int k = 0; k < 2; k++) begin
        if (!sb.written[lower + k]) begin
          store_sample(slr_pkg::IDX_W'(lower + k), pick_sample());
        end
      end
    end
    it.operation    = slr_pkg::OP_REQUEST;
    it.sample_index = slr_pkg::IDX_W'($urandom);
    it.sample_value = $urandom;
    it.point_number = p;
    push_item(it);
  endtask

  task automatic drain();
    idle_cycle();
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic reg_write(slr_pkg::reg_e r, logic [slr_pkg::DATA_W-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(r, v);
    // read back through a second transfer
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== sb.reg_value(r)) begin
      $error("prdata: expected %0h, got %0h", sb.reg_value(r), prdata);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [slr_pkg::DATA_W-1:0] step_v,
                           logic [slr_pkg::DATA_W-1:0] len_v);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    reg_write(slr_pkg::REG_STEP_RATIO, step_v);
    reg_write(slr_pkg::REG_INPUT_LENGTH, len_v);
    n_settings++;
  endtask

  task automatic random_phase(int pct, logic [slr_pkg::DATA_W-1:0] step_v,
                              logic [slr_pkg::DATA_W-1:0] len_v);
    int unsigned hi;
    configure(step_v, len_v);
    idle_pct = pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(99) == 0) drain();
      if ($urandom_range(99) < 30) begin
        hi = (sb.usable_length() > 0) ? sb.usable_length() - 1 : 0;
        if ($urandom_range(1)) begin
          store_sample(slr_pkg::IDX_W'($urandom_range(0, slr_pkg::STORE_DEPTH - 1)),
                       pick_sample());
        end else begin
          store_sample(slr_pkg::IDX_W'($urandom_range(0, hi)), pick_sample());
        end
      end else begin
        request_point(pick_point());
      end
    end
  endtask

  initial begin
    sb         = new();
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    cycles     = 0;
    idle_pct   = 0;
    n_settings = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: step 1.5 over eight samples holding the value extremes.
    configure(32'h0001_8000, 32'd8);
    store_sample(12'd0, 32'sh8000_0000);
    store_sample(12'd1, 32'sh7FFF_FFFF);
    store_sample(12'd2, 32'sh8000_0000);
    store_sample(12'd3, -32'sd1);
    store_sample(12'd4, 32'sd0);
    store_sample(12'd5, 32'sd1);
    store_sample(12'd6, 32'sh7FFF_FFFF);
    store_sample(12'd7, 32'sh8000_0000);
    store_sample(12'hFFF, 32'sh5A5A_5A5A);
    for (int p = 0; p <= 5; p++) request_point(slr_pkg::POINT_W'(p));
    request_point(16'hFFFF);
    request_point(16'h0000);

    // sender idles 15% of the time, then 67%, then never
    random_phase(15, 32'h0001_0000, 32'd4096);
    random_phase(15, 32'd1, 32'd300);
    random_phase(15, 32'h00FF_FFFF, 32'd8191);
    random_phase(67, 32'd0, 32'd2);
    random_phase(67, 32'hAB01_8000, 32'd1);
    random_phase(67, 32'h0000_4000, 32'hFFFF_0100);
    random_phase(0, $urandom_range(1, 24'hFF_FFFF), $urandom_range(0, slr_pkg::STORE_DEPTH));
    random_phase(0, 32'h0002_A3B7, 32'd1000);
    random_phase(0, 32'h0001_0000, 32'd0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() > 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d sample writes, %0d requests in range and %0d out of range",
             sb.n_writes, sb.n_hits, sb.n_misses);
    $display("over %0d register settings, with the sender at 15%%, 67%% and 0%% idle",
             n_settings);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
